### src/single_quote_json_normalizer_macros.svh
// ----------------------------------------------------------------------------
// single_quote_json_normalizer_macros.svh
// Assertion macros for the quote normalizer.
// ----------------------------------------------------------------------------
`ifndef SINGLE_QUOTE_JSON_NORMALIZER_MACROS_SVH
`define SINGLE_QUOTE_JSON_NORMALIZER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SQJN_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sqjn assertion failed");
`define SQJN_ASSERT_IMPL(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sqjn assertion failed");
`define SQJN_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sqjn assertion failed");
`else
`define SQJN_ASSERT(lbl, cond)
`define SQJN_ASSERT_IMPL(lbl, pre, post)
`define SQJN_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### src/sqjn_pkg.sv
// ----------------------------------------------------------------------------
// sqjn_pkg
// Shared constants, types and byte classification for the quote normalizer.
// ----------------------------------------------------------------------------
package sqjn_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_UNDER     = 8'h5F;
    localparam logic [7:0] CH_NUL       = 8'h00;

    // output queue
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } res_t;

    // results of one request, num = 0, 1 or 2
    typedef struct packed {
        logic [1:0] num;
        res_t       r0;
        res_t       r1;
    } wr_pair_t;

    typedef struct packed {
        logic [QCW-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       single_q;
        logic       double_q;
    } conv_t;

    function automatic logic word_byte(input logic [7:0] c);
        word_byte = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c >= 8'h61 && c <= 8'h7A) || (c == CH_UNDER);
    endfunction

    // c with raw neighbors p and n, current flags s and d
    function automatic conv_t convert(input logic [7:0] c, input logic [7:0] p,
                                      input logic [7:0] n, input logic s,
                                      input logic d);
        conv_t r;
        r.data     = c;
        r.single_q = s;
        r.double_q = d;
        if (c == CH_SQUOTE && !d)
        begin
            if (s && word_byte(p) && word_byte(n))
            begin
                r.data = CH_SQUOTE;
            end
            else
            begin
                r.single_q = !s;
                r.data     = CH_DQUOTE;
            end
        end
        else if (c == CH_DQUOTE && !s)
        begin
            r.double_q = !d;
            r.data     = CH_DQUOTE;
        end
        convert = r;
    endfunction

endpackage

### src/sqjn_raw_if.sv
// ----------------------------------------------------------------------------
// sqjn_raw_if
// Request channel carrying raw text bytes.
// ----------------------------------------------------------------------------
interface sqjn_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_in;

    modport source (output valid, output byte_in, output last_in, input ready);
    modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

### src/sqjn_norm_if.sv
// ----------------------------------------------------------------------------
// sqjn_norm_if
// Request channel carrying normalized text bytes.
// ----------------------------------------------------------------------------
interface sqjn_norm_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       last_out;

    modport source (output valid, output byte_out, output last_out, input ready);
    modport sink   (input valid, input byte_out, input last_out, output ready);
endinterface

### src/single_quote_json_normalizer.sv
// Timing: a byte's result is written to the result queue by the request that shows its
//   successor (or that carries last_in), the held byte ahead of the final byte.
// Throughput: one request per cycle while ready is high; each yields up to two results,
//   drained one per cycle while norm.ready is high through a four-entry result queue,
//   which holds ready high up to two entries.
// Reset: rst_n clears the quote flags, the lookahead byte and the queue at once.
// ----------------------------------------------------------------------------
// single_quote_json_normalizer
// Rewrites single-quoted strings in a byte stream as double-quoted strings.
// ----------------------------------------------------------------------------
`include "single_quote_json_normalizer_macros.svh"

module single_quote_json_normalizer (
    input  logic        clk,
    input  logic        rst_n,
    sqjn_raw_if.sink    raw,
    sqjn_norm_if.source norm
);

    sqjn_pkg::wr_pair_t wr;
    sqjn_pkg::q_stat_t  stat;
    logic               space_ok;

    sqjn_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .raw      (raw),
        .space_ok (space_ok),
        .wr       (wr)
    );

    sqjn_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .space_ok (space_ok),
        .stat     (stat),
        .norm     (norm)
    );

    `SQJN_ASSERT(a_count_bound, stat.count <= sqjn_pkg::QCW'(sqjn_pkg::QDEPTH))
    `SQJN_ASSERT_IMPL(a_pair_only_at_end, wr.num == 2'd2, raw.last_in && wr.r1.last)
    `SQJN_ASSERT_NEXT(a_last_emits, raw.valid && raw.ready && raw.last_in, norm.valid)

endmodule

### src/sqjn_core.sv
// ----------------------------------------------------------------------------
// sqjn_core
// Quote state, one-byte lookahead and per-request rewrite decision.
// ----------------------------------------------------------------------------
module sqjn_core (
    input  logic              clk,
    input  logic              rst_n,
    sqjn_raw_if.sink          raw,
    input  logic              space_ok,
    output sqjn_pkg::wr_pair_t wr
);

    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;
    logic [7:0] prev_reg, prev_next;
    logic       single_reg, single_next;
    logic       double_reg, double_next;

    logic            acc;
    logic            collapse;
    logic [7:0]      prev2;
    logic            s2, d2;
    sqjn_pkg::conv_t cv1, cv2;

    assign raw.ready = space_ok;
    assign acc       = raw.valid && raw.ready;

    assign collapse = held_valid_reg && (held_byte_reg == sqjn_pkg::CH_BACKSLASH) &&
                      single_reg && (raw.byte_in == sqjn_pkg::CH_BACKSLASH ||
                                     raw.byte_in == sqjn_pkg::CH_SQUOTE);

    assign cv1   = sqjn_pkg::convert(held_byte_reg, prev_reg, raw.byte_in,
                                     single_reg, double_reg);
    assign prev2 = held_valid_reg ? held_byte_reg : prev_reg;
    assign s2    = held_valid_reg ? cv1.single_q : single_reg;
    assign d2    = held_valid_reg ? cv1.double_q : double_reg;
    assign cv2   = sqjn_pkg::convert(raw.byte_in, prev2, sqjn_pkg::CH_NUL, s2, d2);

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        prev_next       = prev_reg;
        single_next     = single_reg;
        double_next     = double_reg;
        wr              = '0;
        if (acc)
        begin
            if (collapse)
            begin
                wr.num          = 2'd1;
                wr.r0.data      = raw.byte_in;
                wr.r0.last      = raw.last_in;
                prev_next       = raw.byte_in;
                held_valid_next = 1'b0;
            end
            else
            begin
                if (held_valid_reg)
                begin
                    wr.num      = 2'd1;
                    wr.r0.data  = cv1.data;
                    wr.r0.last  = 1'b0;
                    prev_next   = held_byte_reg;
                    single_next = cv1.single_q;
                    double_next = cv1.double_q;
                end
                if (!raw.last_in)
                begin
                    held_byte_next  = raw.byte_in;
                    held_valid_next = 1'b1;
                end
                else if (held_valid_reg)
                begin
                    wr.num     = 2'd2;
                    wr.r1.data = cv2.data;
                    wr.r1.last = 1'b1;
                end
                else
                begin
                    wr.num     = 2'd1;
                    wr.r0.data = cv2.data;
                    wr.r0.last = 1'b1;
                end
            end
            // end of stream clears everything
            if (raw.last_in)
            begin
                held_byte_next  = '0;
                held_valid_next = 1'b0;
                prev_next       = sqjn_pkg::CH_NUL;
                single_next     = 1'b0;
                double_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            prev_reg       <= sqjn_pkg::CH_NUL;
            single_reg     <= 1'b0;
            double_reg     <= 1'b0;
        end
        else
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            prev_reg       <= prev_next;
            single_reg     <= single_next;
            double_reg     <= double_next;
        end
    end

endmodule

### src/sqjn_outq.sv
// ----------------------------------------------------------------------------
// sqjn_outq
// Small result queue: takes up to two results per cycle, sends one while norm is ready.
// ----------------------------------------------------------------------------
module sqjn_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  sqjn_pkg::wr_pair_t wr,
    output logic               space_ok,
    output sqjn_pkg::q_stat_t  stat,
    sqjn_norm_if.source        norm
);

    localparam int QAW = sqjn_pkg::QAW;
    localparam int QCW = sqjn_pkg::QCW;

    sqjn_pkg::res_t mem [sqjn_pkg::QDEPTH];

    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic [QAW-1:0] wr_ptr_p1;
    logic           pop;

    assign wr_ptr_p1     = wr_ptr_reg + QAW'(1);
    assign pop           = norm.valid && norm.ready;
    assign norm.valid    = (count_reg != '0);
    assign norm.byte_out = mem[rd_ptr_reg].data;
    assign norm.last_out = mem[rd_ptr_reg].last;
    assign space_ok      = (count_reg <= QCW'(sqjn_pkg::QDEPTH - 2));
    assign stat.count    = count_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(wr.num);
        rd_ptr_next = pop ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg + QCW'(wr.num) - QCW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (wr.num != 2'd0)
        begin
            mem[wr_ptr_reg] <= wr.r0;
        end
        if (wr.num == 2'd2)
        begin
            mem[wr_ptr_p1] <= wr.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
